[sv/plist_pkg.sv]
package plist_pkg;

    localparam int CAPACITY_DEFAULT = 32;
    localparam int DATA_W           = 32;
    localparam int POS_W            = 6;
    localparam int OP_W             = 3;
    localparam int LEN_W            = 6;
    localparam int S_TDATA_W        = 48;
    localparam int M_TDATA_W        = 48;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_INSERT = 3'd0;
    localparam op_t OP_DELETE = 3'd1;
    localparam op_t OP_GET    = 3'd2;
    localparam op_t OP_FIND   = 3'd3;
    localparam op_t OP_CLEAR  = 3'd4;

    // index register update
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_POS,
        IDX_ZERO,
        IDX_DEC,
        IDX_INC
    } idx_sel_t;

    // memory read address
    typedef enum logic [1:0] {
        RA_IDX_M1,
        RA_IDX,
        RA_POS_M1
    } rd_sel_t;

    // memory write address and data
    typedef enum logic [1:0] {
        WA_IDX,
        WA_IDX_M1,
        WA_POS_M1
    } wr_sel_t;

    // entry count update
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_ZERO
    } cnt_sel_t;

    typedef struct packed {
        logic     capture;
        logic     load_out;
        logic     set_err;
        idx_sel_t idx_sel;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     cap_rd;
        logic     cap_found;
        cnt_sel_t cnt_sel;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic err;
        logic idx_ge_pos;
        logic idx_lt_count;
        logic match;
        logic out_free;
    } stat_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int count_w(input int depth);
        return $clog2(depth + 1);
    endfunction

    // index width: holds the count and any position, plus one
    function automatic int idx_w(input int depth);
        return ((count_w(depth) > POS_W) ? count_w(depth) : POS_W) + 1;
    endfunction

endpackage

[sv/plist_ram.sv]
module plist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/plist_ctrl.sv]
module plist_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  plist_pkg::stat_t  stat,
    output plist_pkg::cmd_t   cmd
);

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_CHECK     = 12'b0000_0000_0010,
        ST_INS_TEST  = 12'b0000_0000_0100,
        ST_INS_WR    = 12'b0000_0000_1000,
        ST_INS_PUT   = 12'b0000_0001_0000,
        ST_DEL_CAP   = 12'b0000_0010_0000,
        ST_DEL_TEST  = 12'b0000_0100_0000,
        ST_DEL_WR    = 12'b0000_1000_0000,
        ST_GET_CAP   = 12'b0001_0000_0000,
        ST_FIND_TEST = 12'b0010_0000_0000,
        ST_FIND_CMP  = 12'b0100_0000_0000,
        ST_RESULT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.idx_sel   = plist_pkg::IDX_HOLD;
        cmd.rd_sel    = plist_pkg::RA_IDX;
        cmd.wr_sel    = plist_pkg::WA_IDX;
        cmd.cnt_sel   = plist_pkg::CNT_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.err) begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_RESULT;
                end else begin
                    unique case (stat.op)
                        plist_pkg::OP_INSERT: begin
                            cmd.idx_sel = plist_pkg::IDX_COUNT;
                            state_next  = ST_INS_TEST;
                        end
                        plist_pkg::OP_DELETE: begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = plist_pkg::RA_POS_M1;
                            state_next = ST_DEL_CAP;
                        end
                        plist_pkg::OP_GET: begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = plist_pkg::RA_POS_M1;
                            state_next = ST_GET_CAP;
                        end
                        plist_pkg::OP_FIND: begin
                            cmd.idx_sel = plist_pkg::IDX_ZERO;
                            state_next  = ST_FIND_TEST;
                        end
                        plist_pkg::OP_CLEAR: begin
                            cmd.cnt_sel = plist_pkg::CNT_ZERO;
                            state_next  = ST_RESULT;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_INS_TEST: begin
                if (stat.idx_ge_pos) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = plist_pkg::RA_IDX_M1;
                    state_next = ST_INS_WR;
                end else begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = plist_pkg::WA_IDX;
                cmd.idx_sel = plist_pkg::IDX_DEC;
                state_next  = ST_INS_TEST;
            end
            ST_INS_PUT: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = plist_pkg::WA_POS_M1;
                cmd.cnt_sel = plist_pkg::CNT_INC;
                state_next  = ST_RESULT;
            end
            ST_DEL_CAP: begin
                cmd.cap_rd  = 1'b1;
                cmd.idx_sel = plist_pkg::IDX_POS;
                state_next  = ST_DEL_TEST;
            end
            ST_DEL_TEST: begin
                if (stat.idx_lt_count) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = plist_pkg::RA_IDX;
                    state_next = ST_DEL_WR;
                end else begin
                    cmd.cnt_sel = plist_pkg::CNT_DEC;
                    state_next  = ST_RESULT;
                end
            end
            ST_DEL_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = plist_pkg::WA_IDX_M1;
                cmd.idx_sel = plist_pkg::IDX_INC;
                state_next  = ST_DEL_TEST;
            end
            ST_GET_CAP: begin
                cmd.cap_rd = 1'b1;
                state_next = ST_RESULT;
            end
            ST_FIND_TEST: begin
                if (stat.idx_lt_count) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = plist_pkg::RA_IDX;
                    state_next = ST_FIND_CMP;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_FIND_CMP: begin
                if (stat.match) begin
                    cmd.cap_found = 1'b1;
                    state_next    = ST_RESULT;
                end else begin
                    cmd.idx_sel = plist_pkg::IDX_INC;
                    state_next  = ST_FIND_TEST;
                end
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/plist_dp.sv]
module plist_dp #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEFAULT,
    localparam int AW = plist_pkg::addr_w(CAPACITY),
    localparam int CW = plist_pkg::count_w(CAPACITY),
    localparam int XW = plist_pkg::idx_w(CAPACITY)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [plist_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [plist_pkg::M_TDATA_W-1:0]   m_tdata,
    input  plist_pkg::cmd_t                   cmd,
    output plist_pkg::stat_t                  stat
);

    plist_pkg::op_t                op_reg;
    logic [plist_pkg::POS_W-1:0]   pos_reg;
    logic [plist_pkg::DATA_W-1:0]  val_reg;
    logic [CW-1:0]                 count_reg, count_next;
    logic [XW-1:0]                 idx_reg, idx_next;
    logic [plist_pkg::DATA_W-1:0]  rd_reg;
    logic [plist_pkg::LEN_W-1:0]   found_reg;
    logic                          err_reg;

    logic                          m_valid_reg;
    logic                          o_status_reg;
    logic [plist_pkg::DATA_W-1:0]  o_value_reg;
    logic [plist_pkg::LEN_W-1:0]   o_found_reg;
    logic [plist_pkg::LEN_W-1:0]   o_len_reg;
    logic                          o_empty_reg;

    logic [XW-1:0]                 cnt_x, pos_x, idx_m1, pos_m1, idx_p1;
    logic [AW-1:0]                 rd_addr, wr_addr;
    logic [plist_pkg::DATA_W-1:0]  wr_data, rd_data;
    logic                          err;

    assign cnt_x  = XW'(count_reg);
    assign pos_x  = XW'(pos_reg);
    assign idx_m1 = idx_reg - XW'(1);
    assign idx_p1 = idx_reg + XW'(1);
    assign pos_m1 = pos_x - XW'(1);

    // refuse out-of-range positions, a full or empty list and unknown operations up front
    always_comb begin
        unique case (op_reg)
            plist_pkg::OP_INSERT: err = (cnt_x >= XW'(CAPACITY)) || (pos_reg == '0)
                                        || (pos_x > cnt_x + XW'(1));
            plist_pkg::OP_DELETE,
            plist_pkg::OP_GET:    err = (count_reg == '0) || (pos_reg == '0)
                                        || (pos_x > cnt_x);
            plist_pkg::OP_FIND,
            plist_pkg::OP_CLEAR:  err = 1'b0;
            default:              err = 1'b1;
        endcase
    end

    always_comb begin
        unique case (cmd.rd_sel)
            plist_pkg::RA_IDX_M1: rd_addr = idx_m1[AW-1:0];
            plist_pkg::RA_IDX:    rd_addr = idx_reg[AW-1:0];
            plist_pkg::RA_POS_M1: rd_addr = pos_m1[AW-1:0];
            default:              rd_addr = idx_reg[AW-1:0];
        endcase
    end

    always_comb begin
        unique case (cmd.wr_sel)
            plist_pkg::WA_IDX: begin
                wr_addr = idx_reg[AW-1:0];
                wr_data = rd_data;
            end
            plist_pkg::WA_IDX_M1: begin
                wr_addr = idx_m1[AW-1:0];
                wr_data = rd_data;
            end
            plist_pkg::WA_POS_M1: begin
                wr_addr = pos_m1[AW-1:0];
                wr_data = val_reg;
            end
            default: begin
                wr_addr = idx_reg[AW-1:0];
                wr_data = rd_data;
            end
        endcase
    end

    plist_ram #(
        .WIDTH (plist_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        unique case (cmd.idx_sel)
            plist_pkg::IDX_HOLD:  idx_next = idx_reg;
            plist_pkg::IDX_COUNT: idx_next = cnt_x;
            plist_pkg::IDX_POS:   idx_next = pos_x;
            plist_pkg::IDX_ZERO:  idx_next = '0;
            plist_pkg::IDX_DEC:   idx_next = idx_m1;
            plist_pkg::IDX_INC:   idx_next = idx_p1;
            default:              idx_next = idx_reg;
        endcase
    end

    always_comb begin
        unique case (cmd.cnt_sel)
            plist_pkg::CNT_HOLD: count_next = count_reg;
            plist_pkg::CNT_INC:  count_next = count_reg + CW'(1);
            plist_pkg::CNT_DEC:  count_next = count_reg - CW'(1);
            plist_pkg::CNT_ZERO: count_next = '0;
            default:             count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.capture) begin
            op_reg    <= s_tdata[2:0];
            pos_reg   <= s_tdata[8:3];
            val_reg   <= s_tdata[40:9];
            rd_reg    <= '0;
            found_reg <= '0;
            err_reg   <= 1'b0;
        end
        if (cmd.set_err) begin
            err_reg <= 1'b1;
        end
        if (cmd.cap_rd) begin
            rd_reg <= rd_data;
        end
        if (cmd.cap_found) begin
            found_reg <= idx_p1[plist_pkg::LEN_W-1:0];
        end
        if (cmd.load_out) begin
            o_status_reg <= err_reg;
            o_value_reg  <= rd_reg;
            o_found_reg  <= found_reg;
            o_len_reg    <= cnt_x[plist_pkg::LEN_W-1:0];
            o_empty_reg  <= (count_reg == '0);
        end
    end

    assign stat.op           = op_reg;
    assign stat.err          = err;
    assign stat.idx_ge_pos   = (idx_reg >= pos_x);
    assign stat.idx_lt_count = (idx_reg < cnt_x);
    assign stat.match        = (rd_data == val_reg);
    assign stat.out_free     = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, o_empty_reg, o_len_reg, o_found_reg, o_value_reg, o_status_reg};

endmodule

[sv/positional_list_engine.sv]
// Ordered list of up to CAPACITY signed 32-bit words held in a single-port-read,
// single-port-write RAM, with its length in a register. Each input beat carries
// an operation (insert, delete, get, find, clear), a 1-based position and a
// value, and yields exactly one output beat with status, read value, found
// position, new length and an empty flag. One request is worked at a time.
// The RAM's registered read sets the pace: every entry shifted by an insert or
// delete takes a read and then a write, and every entry compared by a find a
// read and then a compare. The next beat is taken as soon as the result is
// loaded into the output register, even while that result waits for m_tready.
// The store needs no clearing after reset: no entry is read before it is written.
module positional_list_engine #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] operation, [8:3] position, [40:9] value, [47:41] zero
    input  logic [plist_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] status, [32:1] read_value, [38:33] found_position,
    // [44:39] list_length, [45] is_empty, [47:46] zero
    output logic [plist_pkg::M_TDATA_W-1:0]   m_tdata
);

    plist_pkg::cmd_t  cmd;
    plist_pkg::stat_t stat;

    // sequencer: decode, shift loops, scan loop, result hand-off
    plist_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // request registers, length, loop index, element store and output register
    plist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

    // hold off the next beat once one has been taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a request is in progress");

    // an empty list always reports zero length
    a_empty_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[45]) |-> (m_tdata[44:39] == '0))
        else $error("empty flag with non-zero length");

    // a refused request returns no data
    a_err_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[32:1] == '0) && (m_tdata[38:33] == '0))
        else $error("error result carries data");

    // a hit from find comes with ok status and no read value
    a_found_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[38:33] != '0)) |-> !m_tdata[0] && (m_tdata[32:1] == '0))
        else $error("found position with error or read value");

    // a new result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("output result overwritten while stalled");

endmodule

[verif/tb_positional_list_engine.sv]
module tb_positional_list_engine;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = plist_pkg::CAPACITY_DEFAULT;
    localparam int RANDOM_ITEMS = 2000;
    // the last beats of the run go through with both sides streaming flat out
    localparam int QUIET_ITEMS  = 250;
    // take the longest op, add both sides' longest gap and allow it many times over
    localparam int STALL_LIMIT  = 40 * (2 * CAPACITY + 40);
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;

    // result codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // operation codes the block does not implement
    localparam plist_pkg::op_t OP_RSVD5 = 3'd5;
    localparam plist_pkg::op_t OP_RSVD7 = 3'd7;

    // one result beat, in the order of its fields
    typedef struct packed {
        logic                         status;
        logic [plist_pkg::DATA_W-1:0] read_value;
        logic [plist_pkg::POS_W-1:0]  found_pos;
        logic [plist_pkg::LEN_W-1:0]  length;
        logic                         empty;
    } list_result_t;

    // one row of the directed table; want only counts where typed is set
    typedef struct packed {
        plist_pkg::op_t               op;
        logic [plist_pkg::POS_W-1:0]  pos;
        logic [plist_pkg::DATA_W-1:0] val;
        logic                         typed;
        list_result_t                 want;
    } stim_row_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [plist_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [plist_pkg::M_TDATA_W-1:0] m_tdata;

    positional_list_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Shadow list: our own copy of the block's contents and length
    // ------------------------------------------------------------------
    logic [plist_pkg::DATA_W-1:0] list_words [CAPACITY];
    int                           list_len = 0;
    list_result_t                 outcomes_due [$];

    // Apply one request to the shadow list and return the beat it must yield.
    function automatic list_result_t list_step_outcome(
            input plist_pkg::op_t op,
            input logic [plist_pkg::POS_W-1:0] pos,
            input logic [plist_pkg::DATA_W-1:0] val);
        list_result_t r;
        int           p;
        int           k;
        r = '0;
        p = int'(pos);
        case (op)
            plist_pkg::OP_INSERT: begin
                if (list_len >= CAPACITY || p < 1 || p > list_len + 1) begin
                    r.status = ST_ERR;
                end else begin
                    // open a hole at p by shifting the tail up one slot
                    for (k = list_len; k >= p; k--)
                        list_words[k] = list_words[k-1];
                    list_words[p-1] = val;
                    list_len++;
                end
            end
            plist_pkg::OP_DELETE: begin
                if (list_len == 0 || p < 1 || p > list_len) begin
                    r.status = ST_ERR;
                end else begin
                    r.read_value = list_words[p-1];
                    for (k = p; k < list_len; k++)
                        list_words[k-1] = list_words[k];
                    list_len--;
                end
            end
            plist_pkg::OP_GET: begin
                if (list_len == 0 || p < 1 || p > list_len)
                    r.status = ST_ERR;
                else
                    r.read_value = list_words[p-1];
            end
            plist_pkg::OP_FIND: begin
                // first match wins; no match is not an error
                for (k = 0; k < list_len; k++) begin
                    if (list_words[k] == val) begin
                        r.found_pos = plist_pkg::POS_W'(k + 1);
                        break;
                    end
                end
            end
            plist_pkg::OP_CLEAR: list_len = 0;
            default:  r.status = ST_ERR;
        endcase
        r.length = plist_pkg::LEN_W'(list_len);
        r.empty  = (list_len == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the scoreboard
    // ------------------------------------------------------------------
    logic rx_gaps_on = 1'b0;
    int   rx_hold    = 0;

    // Now and then drop m_tready for a burst while gaps are enabled.
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_gaps_on && $urandom_range(0, 9) == 0) begin
            rx_hold  <= $urandom_range(0, 16);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    int           fault_count  = 0;
    int           stuck_cycles = 0;
    list_result_t seen;
    list_result_t due;

    // Compare every result beat against the oldest outstanding expectation;
    // the watchdog trips when neither side moves a beat for too long.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.status     = m_tdata[0];
            seen.read_value = m_tdata[32:1];
            seen.found_pos  = m_tdata[38:33];
            seen.length     = m_tdata[44:39];
            seen.empty      = m_tdata[45];
            if (outcomes_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result beat: %h", m_tdata);
            end else begin
                due = outcomes_due.pop_front();
                if (seen.status !== due.status || seen.read_value !== due.read_value ||
                    seen.found_pos !== due.found_pos || seen.length !== due.length ||
                    seen.empty !== due.empty) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"mismatch (exp/got): status %0d/%0d read %h/%h ",
                                  "found %0d/%0d len %0d/%0d empty %0d/%0d"},
                                 due.status, seen.status, due.read_value, seen.read_value,
                                 due.found_pos, seen.found_pos, due.length, seen.length,
                                 due.empty, seen.empty);
                end
            end
        end

        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", stuck_cycles);
            $display("tb_positional_list_engine: done, errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    bit tx_gaps_on = 1'b0;
    int beats_sent = 0;

    // Present one request beat, hold it until taken, then log its outcome.
    // A typed row supplies its own expectation; the shadow list still advances.
    task automatic send_request(input plist_pkg::op_t op,
                                input logic [plist_pkg::POS_W-1:0] pos,
                                input logic [plist_pkg::DATA_W-1:0] val,
                                input logic typed,
                                input list_result_t typed_want);
        list_result_t predicted;
        if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(plist_pkg::S_TDATA_W - plist_pkg::DATA_W - plist_pkg::POS_W
                       - plist_pkg::OP_W){1'b0}}, val, pos, op};
        do @(posedge aclk); while (!s_tready);
        predicted = list_step_outcome(op, pos, val);
        outcomes_due.push_back(typed ? typed_want : predicted);
        beats_sent++;
    endtask

    // Hold the request side idle until every outstanding result has come back.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge aclk);
    endtask

    // Mostly a legal position in 1..hi; now and then anything the field allows.
    function automatic logic [plist_pkg::POS_W-1:0] pick_position(input int hi);
        if (hi < 1 || $urandom_range(0, 9) == 0)
            return plist_pkg::POS_W'($urandom_range(0, 63));
        return plist_pkg::POS_W'($urandom_range(1, hi));
    endfunction

    // A small pool of values makes duplicates, so find must return the first.
    function automatic logic [plist_pkg::DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r < 5)
            return plist_pkg::DATA_W'($urandom_range(0, 3));
        if (r < 7) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic stim_row_t row_of(input plist_pkg::op_t op, input int pos,
                                         input logic [plist_pkg::DATA_W-1:0] val,
                                         input logic typed = 1'b0,
                                         input logic st = ST_OK,
                                         input int len = 0, input logic empty = 1'b0);
        stim_row_t row;
        row              = '0;
        row.op           = op;
        row.pos          = plist_pkg::POS_W'(pos);
        row.val          = val;
        row.typed        = typed;
        row.want.status  = st;
        row.want.length  = plist_pkg::LEN_W'(len);
        row.want.empty   = empty;
        return row;
    endfunction

    stim_row_t directed_rows [$];

    initial begin
        int                           r;
        int                           n;
        int                           i;
        plist_pkg::op_t               op;
        logic [plist_pkg::POS_W-1:0]  pos;
        logic [plist_pkg::DATA_W-1:0] val;
        bit                           quiet;

        // empty list: every position is refused, a find simply misses
        directed_rows.push_back(row_of(plist_pkg::OP_GET,    1,  32'h0000_0000,
                                       1'b1, ST_ERR, 0, 1'b1));
        directed_rows.push_back(row_of(plist_pkg::OP_DELETE, 1,  32'hFFFF_FFFF,
                                       1'b1, ST_ERR, 0, 1'b1));
        directed_rows.push_back(row_of(plist_pkg::OP_FIND,   0,  32'h0000_0000,
                                       1'b1, ST_OK,  0, 1'b1));
        // insert outside 1..length+1
        directed_rows.push_back(row_of(plist_pkg::OP_INSERT, 0,  32'h1234_5678,
                                       1'b1, ST_ERR, 0, 1'b1));
        directed_rows.push_back(row_of(plist_pkg::OP_INSERT, 2,  32'h1234_5678,
                                       1'b1, ST_ERR, 0, 1'b1));
        // build -1, 0, MIN, MAX from the extremes of the value field
        directed_rows.push_back(row_of(plist_pkg::OP_INSERT, 1,  32'h8000_0000,
                                       1'b1, ST_OK,  1, 1'b0));
        directed_rows.push_back(row_of(plist_pkg::OP_INSERT, 2,  32'h7FFF_FFFF,
                                       1'b1, ST_OK,  2, 1'b0));
        directed_rows.push_back(row_of(plist_pkg::OP_INSERT, 1,  32'hFFFF_FFFF));
        directed_rows.push_back(row_of(plist_pkg::OP_INSERT, 2,  32'h0000_0000));
        directed_rows.push_back(row_of(plist_pkg::OP_GET,    4,  32'h0000_0000));
        directed_rows.push_back(row_of(plist_pkg::OP_GET,    1,  32'hFFFF_FFFF));
        directed_rows.push_back(row_of(plist_pkg::OP_FIND,   0,  32'h7FFF_FFFF));
        directed_rows.push_back(row_of(plist_pkg::OP_FIND,   63, 32'h8000_0000));
        directed_rows.push_back(row_of(plist_pkg::OP_FIND,   7,  32'h5555_AAAA));
        // positions past the end, zero and the top of the field
        directed_rows.push_back(row_of(plist_pkg::OP_GET,    5,  32'h0000_0000,
                                       1'b1, ST_ERR, 4, 1'b0));
        directed_rows.push_back(row_of(plist_pkg::OP_GET,    63, 32'h0000_0000,
                                       1'b1, ST_ERR, 4, 1'b0));
        directed_rows.push_back(row_of(plist_pkg::OP_DELETE, 0,  32'h0000_0000,
                                       1'b1, ST_ERR, 4, 1'b0));
        directed_rows.push_back(row_of(plist_pkg::OP_DELETE, 5,  32'h0000_0000,
                                       1'b1, ST_ERR, 4, 1'b0));
        // unused operation codes leave the list alone
        directed_rows.push_back(row_of(OP_RSVD5,  1,  32'h0000_0001,
                                       1'b1, ST_ERR, 4, 1'b0));
        directed_rows.push_back(row_of(plist_pkg::op_t'(OP_RSVD5 + 3'd1), 2, 32'hAAAA_5555,
                                       1'b1, ST_ERR, 4, 1'b0));
        directed_rows.push_back(row_of(OP_RSVD7,  63, 32'hFFFF_FFFF,
                                       1'b1, ST_ERR, 4, 1'b0));
        // remove from the tail, then the head
        directed_rows.push_back(row_of(plist_pkg::OP_DELETE, 4,  32'h0000_0000));
        directed_rows.push_back(row_of(plist_pkg::OP_DELETE, 1,  32'h0000_0000));
        directed_rows.push_back(row_of(plist_pkg::OP_CLEAR,  0,  32'h0000_0000,
                                       1'b1, ST_OK,  0, 1'b1));
        directed_rows.push_back(row_of(plist_pkg::OP_GET,    1,  32'h0000_0000,
                                       1'b1, ST_ERR, 0, 1'b1));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part: gaps on both sides from the start
        tx_gaps_on = 1'b1;
        rx_gaps_on <= 1'b1;
        foreach (directed_rows[row_idx])
            send_request(directed_rows[row_idx].op, directed_rows[row_idx].pos,
                         directed_rows[row_idx].val, directed_rows[row_idx].typed,
                         directed_rows[row_idx].want);
        wait_all_results();

        // random part in episodes: fill to capacity, drain to empty, or mixed
        // traffic; the first episode always fills so the full-list refusal is hit
        n = 0;
        while (beats_sent < directed_rows.size() + RANDOM_ITEMS) begin
            quiet = (beats_sent >= directed_rows.size() + RANDOM_ITEMS - QUIET_ITEMS);
            tx_gaps_on = !quiet && ($urandom_range(0, 3) != 0);
            rx_gaps_on <= !quiet && ($urandom_range(0, 3) != 0);
            r = (n == 0) ? 0 : $urandom_range(0, 9);
            n++;

            if (r < 2) begin
                // fill the list, then knock on every edge of a full one
                while (list_len < CAPACITY)
                    send_request(plist_pkg::OP_INSERT,
                                 plist_pkg::POS_W'($urandom_range(1, list_len + 1)),
                                 pick_value(), 1'b0, '0);
                send_request(plist_pkg::OP_INSERT,
                             plist_pkg::POS_W'($urandom_range(1, CAPACITY + 1)),
                             pick_value(), 1'b0, '0);
                send_request(plist_pkg::OP_GET, plist_pkg::POS_W'(CAPACITY), $urandom,
                             1'b0, '0);
                send_request(plist_pkg::OP_GET, plist_pkg::POS_W'(CAPACITY + 1), $urandom,
                             1'b0, '0);
                send_request(plist_pkg::OP_FIND, plist_pkg::POS_W'($urandom_range(0, 63)),
                             pick_value(), 1'b0, '0);
                // let the block run dry before carrying on
                wait_all_results();
            end else if (r < 4) begin
                // drain to empty, then ask an empty list for more
                while (list_len > 0)
                    send_request(plist_pkg::OP_DELETE,
                                 plist_pkg::POS_W'($urandom_range(1, list_len)),
                                 $urandom, 1'b0, '0);
                send_request(plist_pkg::OP_DELETE, pick_position(1), $urandom, 1'b0, '0);
                send_request(plist_pkg::OP_FIND, plist_pkg::POS_W'($urandom_range(0, 63)),
                             pick_value(), 1'b0, '0);
            end else begin
                for (i = $urandom_range(20, 80); i > 0; i--) begin
                    r   = $urandom_range(0, 99);
                    val = $urandom;
                    pos = plist_pkg::POS_W'($urandom_range(0, 63));
                    if (r < 32 || r >= 95) begin
                        op  = plist_pkg::OP_INSERT;
                        pos = pick_position(list_len + 1);
                        val = pick_value();
                    end else if (r < 52) begin
                        op  = plist_pkg::OP_DELETE;
                        pos = pick_position(list_len);
                    end else if (r < 70) begin
                        op  = plist_pkg::OP_GET;
                        pos = pick_position(list_len);
                    end else if (r < 90) begin
                        op = plist_pkg::OP_FIND;
                        // half the time search for something that is there
                        if (list_len > 0 && $urandom_range(0, 1) == 0)
                            val = list_words[$urandom_range(0, list_len - 1)];
                        else
                            val = pick_value();
                    end else if (r < 92) begin
                        op = plist_pkg::OP_CLEAR;
                    end else begin
                        op = plist_pkg::op_t'($urandom_range(OP_RSVD5, OP_RSVD7));
                    end
                    send_request(op, pos, val, 1'b0, '0);
                end
            end
        end

        // all requests are in; collect the stragglers and watch for extras
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fault_count == 0 && outcomes_due.size() == 0)
            $display("tb_positional_list_engine: done, clean");
        else
            $display("tb_positional_list_engine: done, errors");
        $finish;
    end

endmodule

[files.f]
sv/plist_pkg.sv
sv/plist_ram.sv
sv/plist_ctrl.sv
sv/plist_dp.sv
sv/positional_list_engine.sv
verif/tb_positional_list_engine.sv
